/* rtl/gti_pkg.sv */
// Package for the gesture table interpolator.
// Holds widths, register indexes, action codes and the control struct for the blend lanes.
// No dependencies.
`timescale 1ns / 1ps

package gti_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 18;
    localparam int CLAMP_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int IDX_W      = 8;
    localparam int DEPTH      = 256;
    localparam int COUNT_W    = 9;
    localparam int SCALED_W   = IDX_W + FRAC_W;
    localparam int WORD_W     = 2 * SAMPLE_W;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int BLEND_W    = PROD_W - FRAC_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CLAMP_W-1:0] ONE_Q16   = CLAMP_W'(1) << FRAC_W;
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR       = 1'b1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic adv3;
        logic adv4;
        logic zero;
        logic mirror;
    } gti_lerp_ctrl_t;

endpackage

/* rtl/gesture_table_interpolator.sv */
// Gesture table interpolator: a 256-entry table of signed Q2.14 (dx, dy) samples with
// piecewise-linear lookup. Load items write one entry and give no result; query items
// give one result each. Sustained rate is one item per clock while the output is not stalled;
// a query result passes through registered stages for position scaling, dual-port table
// read, blend multiply, and round and mirror. Every stage advances on its own, so bubbles
// are squeezed out while the output is stalled.
// Configuration is to be written by the user only while idle; the block does not enforce it.
// Depends on gti_pkg, gti_table and gti_lerp.
`timescale 1ns / 1ps

module gesture_table_interpolator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gti_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gti_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic [gti_pkg::IDX_W-1:0]           entry_index,
    input  logic signed [gti_pkg::SAMPLE_W-1:0] entry_dx,
    input  logic signed [gti_pkg::SAMPLE_W-1:0] entry_dy,
    input  logic signed [gti_pkg::POS_W-1:0]    position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [gti_pkg::SAMPLE_W-1:0] out_dx,
    output logic signed [gti_pkg::SAMPLE_W-1:0] out_dy
);
    import gti_pkg::*;

    logic [COUNT_W-1:0]  sample_count_reg;
    logic                mirror_reg;

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic                act1_reg;
    logic                zero1_reg, zero2_reg, zero3_reg;
    logic [SCALED_W-1:0] scaled1_reg;
    logic [IDX_W-1:0]    idx1_reg;
    logic [WORD_W-1:0]   wdata1_reg;
    logic [FRAC_W-1:0]   frac2_reg;

    logic                adv1, adv2, adv3, adv4;
    logic                accept;
    logic [COUNT_W-1:0]  n_eff;
    logic [COUNT_W-1:0]  n_m1_full;
    logic [IDX_W-1:0]    n_m1;
    logic [CLAMP_W-1:0]  pos_c;
    logic [SCALED_W-1:0] scaled;
    logic [IDX_W-1:0]    i0, i1;
    logic                wr_en, rd_en;
    logic [WORD_W-1:0]   word_a, word_b;
    gti_lerp_ctrl_t      lerp_ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            mirror_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data;
                CFG_MIRROR:       mirror_reg       <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // each stage advances when it is empty or its successor advances
    always_comb
    begin
        adv4     = !v4_reg || !out_stall;
        adv3     = !v3_reg || adv4;
        adv2     = !v2_reg || adv3;
        adv1     = !v1_reg || adv2;
        in_stall = !adv1;
        accept   = in_valid && adv1;
    end

    always_comb
    begin
        n_eff     = (sample_count_reg > MAX_COUNT) ? MAX_COUNT : sample_count_reg;
        n_m1_full = n_eff - COUNT_W'(1);
        n_m1      = n_m1_full[IDX_W-1:0];
        if (position[POS_W-1])
        begin
            pos_c = '0;
        end
        else if (position[CLAMP_W-1:0] > ONE_Q16)
        begin
            pos_c = ONE_Q16;
        end
        else
        begin
            pos_c = position[CLAMP_W-1:0];
        end
        scaled = SCALED_W'(pos_c * n_m1);
    end

    // stage 1: scale the position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act1_reg    <= action;
            zero1_reg   <= (n_eff == '0);
            scaled1_reg <= scaled;
            idx1_reg    <= entry_index;
            wdata1_reg  <= {entry_dx, entry_dy};
        end
    end

    // stage 2: table access; loads write here and retire, in order with queries
    always_comb
    begin
        i0    = scaled1_reg[SCALED_W-1:FRAC_W];
        i1    = (i0 == n_m1) ? i0 : i0 + IDX_W'(1);
        wr_en = adv2 && v1_reg && (act1_reg == ACT_LOAD);
        rd_en = adv2 && v1_reg && (act1_reg == ACT_QUERY);
    end

    gti_table u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (idx1_reg),
        .wr_data   (wdata1_reg),
        .rd_en     (rd_en),
        .rd_addr_a (i0),
        .rd_addr_b (i1),
        .rd_data_a (word_a),
        .rd_data_b (word_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv2)
            begin
                v2_reg <= v1_reg && (act1_reg == ACT_QUERY);
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            frac2_reg <= scaled1_reg[FRAC_W-1:0];
            zero2_reg <= zero1_reg;
        end
        if (adv3)
        begin
            zero3_reg <= zero2_reg;
        end
    end

    // stages 3 and 4: blend each component
    always_comb
    begin
        lerp_ctrl.adv3   = adv3 && v2_reg;
        lerp_ctrl.adv4   = adv4 && v3_reg;
        lerp_ctrl.zero   = zero3_reg;
        lerp_ctrl.mirror = mirror_reg;
    end

    gti_lerp u_lerp_dx (
        .clk    (clk),
        .ctrl   (lerp_ctrl),
        .a      (word_a[WORD_W-1:SAMPLE_W]),
        .b      (word_b[WORD_W-1:SAMPLE_W]),
        .frac   (frac2_reg),
        .result (out_dx)
    );

    gti_lerp u_lerp_dy (
        .clk    (clk),
        .ctrl   (lerp_ctrl),
        .a      (word_a[SAMPLE_W-1:0]),
        .b      (word_b[SAMPLE_W-1:0]),
        .frac   (frac2_reg),
        .result (out_dy)
    );

    assign out_valid = v4_reg;

endmodule

/* rtl/gti_table.sv */
// Sample table: one write port and two registered read ports, one packed {dx, dy} word per entry.
// Depends on gti_pkg.
`timescale 1ns / 1ps

module gti_table (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [gti_pkg::IDX_W-1:0]    wr_addr,
    input  logic [gti_pkg::WORD_W-1:0]   wr_data,
    input  logic                         rd_en,
    input  logic [gti_pkg::IDX_W-1:0]    rd_addr_a,
    input  logic [gti_pkg::IDX_W-1:0]    rd_addr_b,
    output logic [gti_pkg::WORD_W-1:0]   rd_data_a,
    output logic [gti_pkg::WORD_W-1:0]   rd_data_b
);
    import gti_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_a_reg;
    logic [WORD_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data while the stage is stalled
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

/* rtl/gti_lerp.sv */
// One component lane: difference times fraction, then round, add base, mirror or zero, and hold the result.
// Depends on gti_pkg.
`timescale 1ns / 1ps

module gti_lerp (
    input  logic                              clk,
    input  gti_pkg::gti_lerp_ctrl_t           ctrl,
    input  logic signed [gti_pkg::SAMPLE_W-1:0] a,
    input  logic signed [gti_pkg::SAMPLE_W-1:0] b,
    input  logic [gti_pkg::FRAC_W-1:0]        frac,
    output logic signed [gti_pkg::SAMPLE_W-1:0] result
);
    import gti_pkg::*;

    logic signed [SAMPLE_W-1:0] a3_reg;
    logic signed [PROD_W-1:0]   prod3_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W-1:0]   frac_s;
    logic signed [PROD_W-1:0]   rounded;
    logic signed [BLEND_W-1:0]  blend;
    logic signed [BLEND_W-1:0]  sum;
    logic signed [SAMPLE_W-1:0] lerp;
    logic signed [SAMPLE_W-1:0] out_next;

    localparam logic signed [PROD_W-1:0]   HALF    = PROD_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [SAMPLE_W-1:0] SMIN    = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SMAX    = {1'b0, {(SAMPLE_W-1){1'b1}}};

    always_comb
    begin
        diff   = DIFF_W'(b) - DIFF_W'(a);
        frac_s = $signed({1'b0, frac});
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv3)
        begin
            a3_reg    <= a;
            prod3_reg <= diff * frac_s;
        end
    end

    always_comb
    begin
        rounded = prod3_reg + HALF;
        blend   = rounded[PROD_W-1:FRAC_W];
        sum     = BLEND_W'(a3_reg) + blend;
        lerp    = sum[SAMPLE_W-1:0];
        if (ctrl.zero)
        begin
            out_next = '0;
        end
        else if (ctrl.mirror)
        begin
            out_next = (lerp == SMIN) ? SMAX : -lerp;
        end
        else
        begin
            out_next = lerp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv4)
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule

/* verif/tb_gesture_table_interpolator.sv */
// Self-checking testbench for gesture_table_interpolator: loads offset tables and checks
// interpolated query results against an in-bench scoreboard, under random stalls and gaps.
// Depends on gti_pkg and the gesture_table_interpolator RTL.
`timescale 1ns / 1ps

module tb_gesture_table_interpolator;
    import gti_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PHASE_ITEMS    = 120;
    localparam int SB_DEPTH       = 64;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] dx;
        logic signed [SAMPLE_W-1:0] dy;
    } offset_t;

    class lerp_scoreboard;
        logic signed [SAMPLE_W-1:0] dx_tbl[DEPTH];
        logic signed [SAMPLE_W-1:0] dy_tbl[DEPTH];
        logic [COUNT_W-1:0]         count;
        logic                       mirror;
        offset_t                    exp_fifo[SB_DEPTH];
        int                         exp_wr;
        int                         exp_rd;
        int                         errors;
        int                         n_loads;
        int                         n_queries;
        int                         n_checked;

        function new();
            foreach (dx_tbl[i])
            begin
                dx_tbl[i] = '0;
                dy_tbl[i] = '0;
            end
            count     = '0;
            mirror    = 1'b0;
            exp_wr    = 0;
            exp_rd    = 0;
            errors    = 0;
            n_loads   = 0;
            n_queries = 0;
            n_checked = 0;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_SAMPLE_COUNT)
                count = data[COUNT_W-1:0];
            else if (idx == CFG_MIRROR)
                mirror = data[0];
        endfunction

        // Round to nearest, halves toward plus infinity: arithmetic shift floors.
        function longint blend_q16(longint a, longint b, longint frac);
            return a + (((b - a) * frac + 32768) >>> FRAC_W);
        endfunction

        function logic signed [SAMPLE_W-1:0] apply_mirror(longint v);
            if (mirror)
            begin
                v = -v;
                if (v > 32767)
                    v = 32767;
            end
            return SAMPLE_W'(v);
        endfunction

        function offset_t predict_offset(logic signed [POS_W-1:0] pos);
            int      n;
            longint  p;
            longint  scaled;
            longint  frac;
            longint  i0;
            longint  i1;
            longint  rx;
            longint  ry;
            offset_t r;
            n  = (count > MAX_COUNT) ? DEPTH : int'(count);
            rx = 0;
            ry = 0;
            if (n == 1)
            begin
                rx = dx_tbl[0];
                ry = dy_tbl[0];
            end
            else if (n >= 2)
            begin
                p = pos;
                if (p < 0)
                    p = 0;
                if (p > 65536)
                    p = 65536;
                scaled = p * (n - 1);
                i0     = scaled >>> FRAC_W;
                frac   = scaled & 64'hFFFF;
                if (i0 > n - 1)
                    i0 = n - 1;
                i1 = (i0 + 1 < n) ? i0 + 1 : n - 1;
                rx = blend_q16(dx_tbl[i0], dx_tbl[i1], frac);
                ry = blend_q16(dy_tbl[i0], dy_tbl[i1], frac);
            end
            r.dx = apply_mirror(rx);
            r.dy = apply_mirror(ry);
            return r;
        endfunction

        function void note_item(logic act, logic [IDX_W-1:0] idx,
                                logic signed [SAMPLE_W-1:0] dx,
                                logic signed [SAMPLE_W-1:0] dy,
                                logic signed [POS_W-1:0] pos);
            if (act == ACT_LOAD)
            begin
                dx_tbl[idx] = dx;
                dy_tbl[idx] = dy;
                n_loads++;
            end
            else
            begin
                exp_fifo[exp_wr % SB_DEPTH] = predict_offset(pos);
                exp_wr++;
                n_queries++;
            end
        endfunction

        function void check_offset(logic signed [SAMPLE_W-1:0] dx,
                                   logic signed [SAMPLE_W-1:0] dy);
            offset_t exp_off;
            if (exp_wr == exp_rd)
            begin
                $error("unexpected result out_dx=%0d out_dy=%0d", dx, dy);
                errors++;
                return;
            end
            exp_off = exp_fifo[exp_rd % SB_DEPTH];
            exp_rd++;
            n_checked++;
            if (dx !== exp_off.dx)
            begin
                $error("out_dx expected %0d actual %0d", exp_off.dx, dx);
                errors++;
            end
            if (dy !== exp_off.dy)
            begin
                $error("out_dy expected %0d actual %0d", exp_off.dy, dy);
                errors++;
            end
        endfunction

        function int pending();
            return exp_wr - exp_rd;
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic                       action;
    logic [IDX_W-1:0]           entry_index;
    logic signed [SAMPLE_W-1:0] entry_dx;
    logic signed [SAMPLE_W-1:0] entry_dy;
    logic signed [POS_W-1:0]    position;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] out_dx;
    logic signed [SAMPLE_W-1:0] out_dy;

    lerp_scoreboard sb = new();
    bit             loaded[DEPTH];
    int             snd_idle_pct;
    int             rcv_idle_pct;
    int             idle_cycles;
    int             n_settings;

    gesture_table_interpolator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .entry_index (entry_index),
        .entry_dx    (entry_dx),
        .entry_dy    (entry_dy),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_dx      (out_dx),
        .out_dy      (out_dy)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_offset(out_dx, out_dy);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_gesture_table_interpolator NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] rand_position();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return POS_W'(65536);
            2: return POS_W'(65535);
            3: return POS_W'(-1);
            4, 5: return POS_W'($urandom);
            default: return POS_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                             input logic signed [SAMPLE_W-1:0] dx,
                             input logic signed [SAMPLE_W-1:0] dy,
                             input logic signed [POS_W-1:0] pos);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        entry_index <= idx;
        entry_dx    <= dx;
        entry_dy    <= dy;
        position    <= pos;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(act, idx, dx, dy, pos);
        if (act == ACT_LOAD)
            loaded[idx] = 1'b1;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_config(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int cnt, input bit mir);
        int n;
        n_settings++;
        write_reg(CFG_SAMPLE_COUNT, CFG_DATA_W'(cnt));
        write_reg(CFG_MIRROR, CFG_DATA_W'(mir));
        n = (cnt > DEPTH) ? DEPTH : cnt;
        for (int k = 0; k < n; k++)
            if (!loaded[k])
                send_item(ACT_LOAD, IDX_W'(k), rand_sample(), rand_sample(), rand_position());
        for (int k = 0; k < PHASE_ITEMS; k++)
            if ($urandom_range(0, 9) < 6)
                send_item(ACT_QUERY, IDX_W'($urandom), rand_sample(), rand_sample(),
                          rand_position());
            else
                send_item(ACT_LOAD, IDX_W'($urandom_range(0, DEPTH - 1)), rand_sample(),
                          rand_sample(), rand_position());
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        action       = ACT_LOAD;
        entry_index  = '0;
        entry_dx     = '0;
        entry_dy     = '0;
        position     = '0;
        idle_cycles  = 0;
        n_settings   = 1;
        snd_idle_pct = 20;
        rcv_idle_pct = 66;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table after reset: every query gives zero.
        send_item(ACT_QUERY, 8'hFF, 16'sh7FFF, 16'sh8000, 18'sd0);
        send_item(ACT_QUERY, 8'h00, 16'sh8000, 16'sh7FFF, 18'sd131071);
        send_item(ACT_QUERY, 8'hFF, 16'shFFFF, 16'sh0000, -18'sd131072);
        send_item(ACT_LOAD, 8'd0, 16'sh8000, 16'sh7FFF, 18'sd0);
        send_item(ACT_LOAD, 8'd255, 16'sh7FFF, 16'sh8000, 18'sd0);
        send_item(ACT_LOAD, 8'd1, 16'sh7FFF, 16'sh8000, 18'sd0);

        // Single entry, mirrored: the most negative sample saturates.
        n_settings++;
        write_reg(CFG_SAMPLE_COUNT, 9'd1);
        write_reg(CFG_MIRROR, 9'd1);
        send_item(ACT_QUERY, 8'd0, 16'sd0, 16'sd0, 18'sd12345);
        n_settings++;
        write_reg(CFG_MIRROR, 9'd0);
        send_item(ACT_QUERY, 8'd0, 16'sd0, 16'sd0, 18'sd40000);

        // Two entries at full-scale spread: ends, midpoint, rounding, clamping.
        n_settings++;
        write_reg(CFG_SAMPLE_COUNT, 9'd2);
        send_item(ACT_QUERY, 8'd0, 16'sd0, 16'sd0, 18'sd0);
        send_item(ACT_QUERY, 8'd0, 16'sd0, 16'sd0, 18'sd65536);
        send_item(ACT_QUERY, 8'd0, 16'sd0, 16'sd0, 18'sd32768);
        send_item(ACT_QUERY, 8'd0, 16'sd0, 16'sd0, 18'sd1);
        send_item(ACT_QUERY, 8'd0, 16'sd0, 16'sd0, 18'sd65535);
        send_item(ACT_QUERY, 8'd0, 16'sd0, 16'sd0, 18'sd131071);
        send_item(ACT_QUERY, 8'd0, 16'sd0, 16'sd0, -18'sd5);
        n_settings++;
        write_reg(CFG_MIRROR, 9'd1);
        send_item(ACT_QUERY, 8'd0, 16'sd0, 16'sd0, 18'sd32768);

        run_phase(2, 1'b1);
        run_phase(9, 1'b0);
        run_phase(256, 1'b1);
        snd_idle_pct = 66;
        rcv_idle_pct = 20;
        run_phase(511, 1'b0);
        run_phase(1, 1'b1);
        run_phase(0, 1'b1);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_phase(37, 1'b0);
        run_phase(256, 1'b1);
        run_phase(3, 1'b0);

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d table loads and %0d queries over %0d register settings;",
                 sb.n_loads, sb.n_queries, n_settings);
        $display("%0d interpolated offsets checked, %0d mismatches.", sb.n_checked, sb.errors);
        if (sb.errors == 0)
            $display("tb_gesture_table_interpolator OK");
        else
            $display("tb_gesture_table_interpolator NOT OK");
        $finish;
    end

endmodule

/* files.f */
rtl/gti_pkg.sv
rtl/gti_table.sv
rtl/gti_lerp.sv
rtl/gesture_table_interpolator.sv
verif/tb_gesture_table_interpolator.sv
